FILE: hw/rtl/fsss_pkg.sv
// Shared types, constants and codes for the fixed-timestep step scheduler.
package fsss_pkg;

  localparam int TICK_W  = 64;
  localparam int STEP_W  = 32;
  localparam int MAX_W   = 6;
  localparam int PAUSE_W = 63;
  localparam int REM_W   = 32;
  // capped accumulator never exceeds step_ticks * max(max_steps, 1)
  localparam int ACC_W   = STEP_W + MAX_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TICKS = 2'd2;

  localparam logic [MAX_W-1:0] MAX_STEPS_RESET = 6'd5;
  localparam logic [MAX_W-1:0] STEP_LIMIT      = 6'd63;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_PAUSE = 1'b1;

  localparam logic RES_STEP    = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PAUSE,
    CMD_VAR,
    CMD_FIXED
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [TICK_W-1:0] value;   // frame delta, or pause request amount
  } cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_ticks;
    logic [MAX_W-1:0]  max_steps;
    logic [STEP_W-1:0] first_ticks;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [TICK_W-1:0]  sim_ticks;
    logic [TICK_W-1:0]  step_delta;
    logic [REM_W-1:0]   remainder_ticks;
    logic [PAUSE_W-1:0] pause_left;
    logic               paused;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DISPATCH,
    B_VSTEP,
    B_CAP,
    B_SUB,
    B_APPLY,
    B_SUMMARY
  } back_state_t;

endpackage

FILE: hw/rtl/fixed_timestep_step_scheduler.sv
// Top level of the fixed-timestep step scheduler: config registers and wiring.
//
//  channel | handshake           | beat contents
//  --------+---------------------+------------------------------------------------
//  input   | push / full         | func, now_ticks, pause_amount
//  result  | empty / pop         | kind, sim_ticks, step_delta, remainder_ticks,
//          |                     | pause_left, paused, last
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
// Input beats go into a two-entry command queue; the back end runs one command
// at a time. A pause request passes dispatch and summary; a variable-mode frame
// adds a step state unless paused; a fixed-mode frame caps the accumulator and
// then runs the back end's subtract-then-apply step loop.
// Synchronous reset clears control state and loads register defaults; no sweep.
// A full result queue stalls the back end; the front keeps filling its queue.
module fixed_timestep_step_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            func,
  input  logic [fsss_pkg::TICK_W-1:0]     now_ticks,
  input  logic [fsss_pkg::PAUSE_W-1:0]    pause_amount,
  output logic                            empty,
  input  logic                            pop,
  output logic                            kind,
  output logic [fsss_pkg::TICK_W-1:0]     sim_ticks,
  output logic [fsss_pkg::TICK_W-1:0]     step_delta,
  output logic [fsss_pkg::REM_W-1:0]      remainder_ticks,
  output logic [fsss_pkg::PAUSE_W-1:0]    pause_left,
  output logic                            paused,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsss_pkg::STEP_W-1:0]     cfg_data
);
  import fsss_pkg::*;

  cfg_t cfg;
  cmd_t cmd_wr_data;
  cmd_t cmd_head;
  res_t res_wr_data;
  res_t res_head;
  logic cmd_wr_en;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  logic res_push;
  logic res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_ticks  <= '0;
      cfg.max_steps   <= MAX_STEPS_RESET;
      cfg.first_ticks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_TICKS:  cfg.step_ticks  <= cfg_data;
        CFG_MAX_STEPS:   cfg.max_steps   <= cfg_data[MAX_W-1:0];
        CFG_FIRST_TICKS: cfg.first_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  fsss_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .func         (func),
    .now_ticks    (now_ticks),
    .pause_amount (pause_amount),
    .q_wr_en      (cmd_wr_en),
    .q_wr_data    (cmd_wr_data),
    .q_full       (cmd_full)
  );

  fsss_cmd_q u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr_en),
    .wr_data (cmd_wr_data),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  fsss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wr_data)
  );

  fsss_res_q u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign kind            = res_head.kind;
  assign sim_ticks       = res_head.sim_ticks;
  assign step_delta      = res_head.step_delta;
  assign remainder_ticks = res_head.remainder_ticks;
  assign pause_left      = res_head.pause_left;
  assign paused          = res_head.paused;
  assign last            = res_head.last;

`ifndef ASSERT_OFF
  a_paused_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (paused == (pause_left != '0)))
    else $error("paused flag disagrees with pause_left");

  a_step_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == RES_STEP) |-> (!last && remainder_ticks == '0))
    else $error("step result marked last or carrying a remainder");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == RES_SUMMARY) |-> last)
    else $error("summary result without last");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule

FILE: hw/rtl/fsss_cmd_q.sv
// Two-entry command queue between the front and back ends.
module fsss_cmd_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  fsss_pkg::cmd_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output fsss_pkg::cmd_t  rd_data,
  output logic            empty
);
  import fsss_pkg::*;

  cmd_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               wr_ok;
  logic               rd_ok;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(wr_ok) - Q_CNT_W'(rd_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/fsss_res_q.sv
// Two-entry result queue driving the output side.
module fsss_res_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  fsss_pkg::res_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output fsss_pkg::res_t  rd_data,
  output logic            empty
);
  import fsss_pkg::*;

  res_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               wr_ok;
  logic               rd_ok;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(wr_ok) - Q_CNT_W'(rd_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/fsss_front.sv
// Front end: takes input beats, measures frame deltas and classifies commands.
module fsss_front (
  input  logic                          clk,
  input  logic                          rst,
  input  fsss_pkg::cfg_t                cfg,
  input  logic                          push,
  output logic                          full,
  input  logic                          func,
  input  logic [fsss_pkg::TICK_W-1:0]   now_ticks,
  input  logic [fsss_pkg::PAUSE_W-1:0]  pause_amount,
  output logic                          q_wr_en,
  output fsss_pkg::cmd_t                q_wr_data,
  input  logic                          q_full
);
  import fsss_pkg::*;

  logic [TICK_W-1:0] prev_sample;
  logic              started;
  logic              accept;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign q_wr_en = accept;

  always_comb begin
    if (func == FUNC_PAUSE) begin
      q_wr_data.kind  = CMD_PAUSE;
      q_wr_data.value = TICK_W'(pause_amount);
    end else begin
      q_wr_data.kind  = (cfg.step_ticks == '0) ? CMD_VAR : CMD_FIXED;
      // first frame pretends a configured delta; later ones wrap modulo 2^64
      q_wr_data.value = started ? (now_ticks - prev_sample) : TICK_W'(cfg.first_ticks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      started     <= 1'b0;
    end else if (accept && func == FUNC_FRAME) begin
      prev_sample <= now_ticks;
      started     <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/fsss_back.sv
// Back end: runs each command, steps the accumulator and queues results.
module fsss_back (
  input  logic            clk,
  input  logic            rst,
  input  fsss_pkg::cfg_t  cfg,
  input  logic            cmd_empty,
  input  fsss_pkg::cmd_t  cmd_head,
  output logic            cmd_pop,
  input  logic            res_full,
  output logic            res_push,
  output fsss_pkg::res_t  res_data
);
  import fsss_pkg::*;

  back_state_t        state, state_next;
  cmd_kind_t          cur_kind, cur_kind_next;
  logic [TICK_W-1:0]  cur_value, cur_value_next;
  logic [ACC_W-1:0]   cap, cap_next;
  logic [TICK_W-1:0]  work, work_next;
  logic [ACC_W-1:0]   acc, acc_next;
  logic [ACC_W-1:0]   a_q, a_next;
  logic [PAUSE_W-1:0] pdiff, pdiff_next;
  logic               p_lt, p_lt_next;
  logic [PAUSE_W-1:0] pause, pause_next;
  logic [TICK_W-1:0]  total, total_next;
  logic [MAX_W-1:0]   n_steps, n_steps_next;

  logic [TICK_W:0]    sum;
  logic [TICK_W:0]    pv;
  logic [ACC_W:0]     diff;
  logic [PAUSE_W:0]   psub;
  logic [MAX_W-1:0]   mx;
  logic [STEP_W-1:0]  p;
  logic               a_gt_p;
  logic [ACC_W-1:0]   base;
  logic [ACC_W-1:0]   acc_apply;
  logic [PAUSE_W-1:0] pause_apply;
  logic               emit;
  logic               res_kind;
  logic [TICK_W-1:0]  res_delta;
  logic [REM_W-1:0]   res_rem;

  assign sum  = (TICK_W+1)'(acc) + (TICK_W+1)'(cur_value);
  assign pv   = (TICK_W+1)'(pause) - (TICK_W+1)'(cur_value);
  assign diff = (ACC_W+1)'(acc) - (ACC_W+1)'(cfg.step_ticks);
  assign psub = (PAUSE_W+1)'(pause) - (PAUSE_W+1)'(cfg.step_ticks);
  assign mx   = (cfg.max_steps == '0) ? MAX_W'(1) : cfg.max_steps;

  // one iteration of the step loop, using acc - step from the previous cycle
  assign p      = pause[STEP_W-1:0];
  assign a_gt_p = a_q > ACC_W'(p);
  assign base   = a_gt_p ? a_q : acc;

  always_comb begin
    if (pause == '0) begin
      emit        = 1'b1;
      acc_apply   = a_q;
      pause_apply = pause;
    end else if (!p_lt) begin
      emit        = 1'b0;
      acc_apply   = a_q;
      pause_apply = pdiff;
    end else begin
      // pause ends inside this step: swallow it, or take P more and emit
      emit        = a_gt_p;
      acc_apply   = base - ACC_W'(p);
      pause_apply = '0;
    end
  end

  always_comb begin
    state_next     = state;
    cur_kind_next  = cur_kind;
    cur_value_next = cur_value;
    cap_next       = cap;
    work_next      = work;
    acc_next       = acc;
    a_next         = a_q;
    pdiff_next     = pdiff;
    p_lt_next      = p_lt;
    pause_next     = pause;
    total_next     = total;
    n_steps_next   = n_steps;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res_kind       = RES_STEP;
    res_delta      = '0;
    res_rem        = '0;

    case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop        = 1'b1;
          cur_kind_next  = cmd_head.kind;
          cur_value_next = cmd_head.value;
          state_next     = B_DISPATCH;
        end
      end
      B_DISPATCH: begin
        case (cur_kind)
          CMD_PAUSE: begin
            if (cur_value[PAUSE_W-1:0] > pause) begin
              pause_next = cur_value[PAUSE_W-1:0];
            end
            state_next = B_SUMMARY;
          end
          CMD_VAR: begin
            if (pause != '0) begin
              pause_next = pv[TICK_W] ? '0 : pv[PAUSE_W-1:0];
              state_next = B_SUMMARY;
            end else begin
              state_next = B_VSTEP;
            end
          end
          CMD_FIXED: begin
            work_next  = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
            cap_next   = ACC_W'(cfg.step_ticks) * ACC_W'(mx);
            state_next = B_CAP;
          end
          default: begin
            state_next = B_SUMMARY;
          end
        endcase
      end
      B_VSTEP: begin
        if (!res_full) begin
          total_next = total + cur_value;
          res_push   = 1'b1;
          res_delta  = cur_value;
          state_next = B_SUMMARY;
        end
      end
      B_CAP: begin
        acc_next     = (work > TICK_W'(cap)) ? cap : work[ACC_W-1:0];
        n_steps_next = '0;
        state_next   = B_SUB;
      end
      B_SUB: begin
        if (diff[ACC_W]) begin
          state_next = B_SUMMARY;
        end else begin
          a_next     = diff[ACC_W-1:0];
          pdiff_next = psub[PAUSE_W-1:0];
          p_lt_next  = psub[PAUSE_W];
          state_next = B_APPLY;
        end
      end
      B_APPLY: begin
        if (emit && n_steps != STEP_LIMIT) begin
          if (!res_full) begin
            total_next   = total + TICK_W'(cfg.step_ticks);
            n_steps_next = n_steps + 1'b1;
            acc_next     = acc_apply;
            pause_next   = pause_apply;
            res_push     = 1'b1;
            res_delta    = TICK_W'(cfg.step_ticks);
            state_next   = B_SUB;
          end
        end else begin
          acc_next   = acc_apply;
          pause_next = pause_apply;
          state_next = B_SUB;
        end
      end
      B_SUMMARY: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res_kind   = RES_SUMMARY;
          res_delta  = (cur_kind == CMD_PAUSE) ? '0 : cur_value;
          if (cfg.step_ticks != '0) begin
            res_rem = (|acc[ACC_W-1:REM_W]) ? '1 : acc[REM_W-1:0];
          end
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase

    res_data.kind            = res_kind;
    res_data.sim_ticks       = total_next;
    res_data.step_delta      = res_delta;
    res_data.remainder_ticks = res_rem;
    res_data.pause_left      = pause_next;
    res_data.paused          = (pause_next != '0);
    res_data.last            = (res_kind == RES_SUMMARY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      acc   <= '0;
      pause <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      pause <= pause_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_kind  <= cur_kind_next;
    cur_value <= cur_value_next;
    cap       <= cap_next;
    work      <= work_next;
    a_q       <= a_next;
    pdiff     <= pdiff_next;
    p_lt      <= p_lt_next;
    n_steps   <= n_steps_next;
  end

endmodule

FILE: sim/fixed_timestep_step_scheduler_tb.sv
// Self-checking testbench for the fixed-timestep step scheduler.
`timescale 1ns / 1ps

module fixed_timestep_step_scheduler_tb;
  import fsss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 150;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 32;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;

  typedef struct {
    row_op_t              op;
    logic [CFG_IDX_W-1:0] idx;
    logic [STEP_W-1:0]    data;
    logic                 fn;
    logic [TICK_W-1:0]    smp;
    logic [PAUSE_W-1:0]   amt;
    bit                   typed;
    res_t                 sum;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic                 func;
  logic [TICK_W-1:0]    now_ticks;
  logic [PAUSE_W-1:0]   pause_amount;
  logic                 empty;
  logic                 pop;
  logic                 kind;
  logic [TICK_W-1:0]    sim_ticks;
  logic [TICK_W-1:0]    step_delta;
  logic [REM_W-1:0]     remainder_ticks;
  logic [PAUSE_W-1:0]   pause_left;
  logic                 paused;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STEP_W-1:0]    cfg_data;

  // predictor state and its copy of the registers
  logic [TICK_W-1:0] m_prev;
  bit                m_started;
  logic [63:0]       m_acc;
  logic [63:0]       m_pause;
  logic [TICK_W-1:0] m_total;
  logic [STEP_W-1:0] c_step;
  logic [MAX_W-1:0]  c_max;
  logic [STEP_W-1:0] c_first;

  res_t      sched_results_q[$];
  stim_row_t dir_rows[$];

  // summary override for the beat on the input port
  bit   typed_row;
  res_t typed_sum;

  int fail_count;
  int idle_cycles;
  int burst_left;
  int beat_no;

  // generator view of what has been written and sent
  logic [63:0] g_step;
  logic [63:0] g_max;
  logic [63:0] g_prev;

  fixed_timestep_step_scheduler u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [REM_W-1:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic push_result(input logic k, input logic [63:0] d, input logic [31:0] r,
                             input logic l);
    res_t e;
    e.kind            = k;
    e.sim_ticks       = m_total;
    e.step_delta      = d;
    e.remainder_ticks = r;
    e.pause_left      = m_pause[PAUSE_W-1:0];
    e.paused          = (m_pause != 0);
    e.last            = l;
    sched_results_q.push_back(e);
  endtask

  task automatic run_scheduler(input logic fn, input logic [63:0] smp,
                               input logic [PAUSE_W-1:0] amt);
    logic [63:0] delta, st, mx, cap, acc, p, leftover;
    logic [64:0] sum;
    int          nsteps;
    bit          emit;
    if (fn == FUNC_PAUSE) begin
      if ({1'b0, amt} > m_pause) m_pause = {1'b0, amt};
      push_result(RES_SUMMARY, 64'd0, (c_step != 0) ? sat32(m_acc) : 32'd0, 1'b1);
      return;
    end
    if (!m_started) begin
      delta     = {32'd0, c_first};
      m_started = 1'b1;
    end else begin
      delta = smp - m_prev;
    end
    m_prev = smp;
    if (c_step == 0) begin
      if (m_pause != 0) begin
        m_pause = (m_pause > delta) ? m_pause - delta : 64'd0;
      end else begin
        m_total += delta;
        push_result(RES_STEP, delta, 32'd0, 1'b0);
      end
      push_result(RES_SUMMARY, delta, 32'd0, 1'b1);
      return;
    end
    st  = {32'd0, c_step};
    mx  = (c_max == 0) ? 64'd1 : {58'd0, c_max};
    cap = st * mx;
    sum = {1'b0, m_acc} + {1'b0, delta};
    acc = sum[64] ? '1 : sum[63:0];
    if (acc > cap) acc = cap;
    nsteps = 0;
    while (acc >= st) begin
      emit = 1'b0;
      acc -= st;
      if (m_pause != 0) begin
        if (m_pause >= st) begin
          m_pause -= st;
        end else begin
          // pause ends inside this step: the leftover either funds the step or goes back
          p        = m_pause;
          leftover = st - p;
          m_pause  = 64'd0;
          if (leftover + acc > st) begin
            acc -= p;
            emit = 1'b1;
          end else begin
            acc += leftover;
          end
        end
      end else begin
        emit = 1'b1;
      end
      if (emit && nsteps < STEP_LIMIT) begin
        m_total += st;
        push_result(RES_STEP, st, 32'd0, 1'b0);
        nsteps++;
      end
    end
    m_acc = acc;
    push_result(RES_SUMMARY, delta, sat32(acc), 1'b1);
  endtask

  // beat monitor: config, input and result channels, all sampled at the rising edge
  always @(posedge clk) begin
    res_t got, exp_r;
    bit   moved;
    if (rst) begin
      m_prev    = '0;
      m_started = 1'b0;
      m_acc     = '0;
      m_pause   = '0;
      m_total   = '0;
      c_step    = '0;
      c_max     = MAX_STEPS_RESET;
      c_first   = '0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_STEP_TICKS:  c_step  = cfg_data;
          CFG_MAX_STEPS:   c_max   = cfg_data[MAX_W-1:0];
          CFG_FIRST_TICKS: c_first = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        moved = 1'b1;
        run_scheduler(func, now_ticks, pause_amount);
        if (typed_row) sched_results_q[sched_results_q.size()-1] = typed_sum;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        beat_no++;
        got = {kind, sim_ticks, step_delta, remainder_ticks, pause_left, paused, last};
        if (sched_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat %0d with nothing expected: kind %0d sim %h delta %h",
                     beat_no, got.kind, got.sim_ticks, got.step_delta);
        end else begin
          exp_r = sched_results_q.pop_front();
          if (got.kind !== exp_r.kind || got.sim_ticks !== exp_r.sim_ticks ||
              got.step_delta !== exp_r.step_delta ||
              got.remainder_ticks !== exp_r.remainder_ticks ||
              got.pause_left !== exp_r.pause_left || got.paused !== exp_r.paused ||
              got.last !== exp_r.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result beat %0d mismatch", beat_no);
              $display("  exp kind %0d sim %h delta %h rem %h pause %h paused %0d last %0d",
                       exp_r.kind, exp_r.sim_ticks, exp_r.step_delta, exp_r.remainder_ticks,
                       exp_r.pause_left, exp_r.paused, exp_r.last);
              $display("  got kind %0d sim %h delta %h rem %h pause %h paused %0d last %0d",
                       got.kind, got.sim_ticks, got.step_delta, got.remainder_ticks,
                       got.pause_left, got.paused, got.last);
            end
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: pops under one of four stall patterns, redrawn at random
  initial begin
    int          rx_count;
    int          rx_mode;
    logic [31:0] rx_pat;
    rx_count = 0;
    rx_mode  = 0;
    rx_pat   = '1;
    pop      = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_count == 0) begin
        rx_mode  = $urandom_range(0, 3);
        rx_count = $urandom_range(16, 96);
        rx_pat   = $urandom();
      end
      rx_count--;
      case (rx_mode)
        0:       pop = 1'b1;
        1:       pop = rx_pat[rx_count % 32];
        2:       pop = ($urandom_range(0, 3) == 0);
        default: pop = (rx_count % 8) != 0;
      endcase
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(input logic fn, input logic [63:0] smp,
                           input logic [PAUSE_W-1:0] amt, input bit chk, input res_t s);
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    func         = fn;
    now_ticks    = smp;
    pause_amount = amt;
    typed_row    = chk;
    typed_sum    = s;
    push         = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // registers change only with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] d);
    push = 1'b0;
    while (sched_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_index = idx;
    cfg_data  = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic tab_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] d);
    stim_row_t r;
    r = '{op: ROW_CFG, idx: idx, data: d, fn: 1'b0, smp: '0, amt: '0, typed: 1'b0, sum: '0};
    dir_rows.push_back(r);
  endtask

  task automatic tab_item(input logic fn, input logic [63:0] smp,
                          input logic [PAUSE_W-1:0] amt);
    stim_row_t r;
    r = '{op: ROW_ITEM, idx: '0, data: '0, fn: fn, smp: smp, amt: amt, typed: 1'b0, sum: '0};
    dir_rows.push_back(r);
  endtask

  // the summary of the last row is known outright
  task automatic tab_typed(input res_t s);
    dir_rows[dir_rows.size()-1].typed = 1'b1;
    dir_rows[dir_rows.size()-1].sum   = s;
  endtask

  initial begin
    logic [63:0]        r64, span, d64;
    logic [PAUSE_W-1:0] a63;
    logic [STEP_W-1:0]  d32;
    logic               fn;
    res_t               blank;
    rst          = 1'b1;
    push         = 1'b0;
    func         = FUNC_FRAME;
    now_ticks    = '0;
    pause_amount = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_STEP_TICKS;
    cfg_data     = '0;
    typed_row    = 1'b0;
    typed_sum    = '0;
    blank        = '0;
    fail_count   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    beat_no      = 0;
    g_prev       = '0;

    // directed: reset state, first frame, wraps, pause extremes, cap, leftover rule
    tab_item(FUNC_PAUSE, 64'h0, 63'h0);
    tab_typed({RES_SUMMARY, 64'h0, 64'h0, 32'h0, 63'h0, 1'b0, 1'b1});
    tab_cfg(CFG_FIRST_TICKS, 32'hFFFF_FFFF);
    tab_item(FUNC_FRAME, 64'hFFFF_FFFF_FFFF_FFFF, 63'h0);
    tab_typed({RES_SUMMARY, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 32'h0, 63'h0, 1'b0, 1'b1});
    tab_item(FUNC_FRAME, 64'h2, 63'h0);
    tab_item(FUNC_PAUSE, 64'h0, 63'h7FFF_FFFF_FFFF_FFFF);
    tab_typed({RES_SUMMARY, 64'h1_0000_0002, 64'h0, 32'h0, 63'h7FFF_FFFF_FFFF_FFFF,
               1'b1, 1'b1});
    tab_item(FUNC_FRAME, 64'h1002, 63'h0);
    tab_item(FUNC_PAUSE, 64'h0, 63'h0);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1002, 63'h0);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1001, 63'h0);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1001, 63'h0);
    tab_cfg(CFG_STEP_TICKS, 32'd10);
    tab_cfg(CFG_MAX_STEPS, 32'd3);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_101A, 63'h0);
    tab_item(FUNC_PAUSE, 64'h0, 63'd14);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_102E, 63'h0);
    tab_item(FUNC_PAUSE, 64'h0, 63'd3);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1038, 63'h0);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1037, 63'h0);
    tab_cfg(CFG_MAX_STEPS, 32'd0);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_105A, 63'h0);
    tab_cfg(CFG_STEP_TICKS, 32'hFFFF_FFFF);
    tab_cfg(CFG_MAX_STEPS, 32'hFFFF_FFFF);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_105A, 63'h0);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1059, 63'h0);
    tab_item(FUNC_PAUSE, 64'h0, 63'h0);
    tab_cfg(CFG_FIRST_TICKS, 32'h0);
    tab_cfg(CFG_STEP_TICKS, 32'd1);
    tab_cfg(CFG_MAX_STEPS, 32'd1);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1062, 63'h0);
    tab_cfg(CFG_STEP_TICKS, 32'd0);
    tab_item(FUNC_PAUSE, 64'h0, 63'd20);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1069, 63'h0);
    tab_item(FUNC_FRAME, 64'h8000_0000_0000_1087, 63'h0);

    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].fn, dir_rows[i].smp, dir_rows[i].amt,
                  dir_rows[i].typed, dir_rows[i].sum);
        if (dir_rows[i].fn == FUNC_FRAME) g_prev = dir_rows[i].smp;
      end
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 6)
        0:       d32 = 32'd0;
        1:       d32 = $urandom_range(1, 16);
        2:       d32 = $urandom_range(17, 4096);
        3:       d32 = 32'hFFFF_FFFF;
        4:       d32 = $urandom();
        default: d32 = 32'd1;
      endcase
      g_step = {32'd0, d32};
      write_reg(CFG_STEP_TICKS, d32);
      d32 = $urandom();
      case (ph % 4)
        0:       d32[MAX_W-1:0] = 6'd0;
        1:       d32[MAX_W-1:0] = 6'd1;
        2:       d32[MAX_W-1:0] = 6'd63;
        default: d32[MAX_W-1:0] = MAX_W'($urandom_range(2, 62));
      endcase
      g_max = (d32[MAX_W-1:0] == 0) ? 64'd1 : {58'd0, d32[MAX_W-1:0]};
      write_reg(CFG_MAX_STEPS, d32);
      write_reg(CFG_FIRST_TICKS, $urandom());
      span = (g_step == 0) ? 64'd2000 : g_step * (g_max + 1);

      repeat (PHASE_ITEMS) begin
        r64 = {$urandom(), $urandom()};
        a63 = PAUSE_W'({$urandom(), $urandom()});
        fn  = ($urandom_range(0, 4) == 0) ? FUNC_PAUSE : FUNC_FRAME;
        if (fn == FUNC_FRAME) begin
          case ($urandom_range(0, 9))
            0:       d64 = 64'd0;
            1:       d64 = r64;
            2:       d64 = (g_step == 0) ? 64'd1 : g_step + $urandom_range(0, 2) - 1;
            3:       d64 = r64 - g_prev;   // jump to an arbitrary sample
            default: d64 = r64 % (span + 1);
          endcase
          g_prev = g_prev + d64;
          send_item(FUNC_FRAME, g_prev, a63, 1'b0, blank);
        end else begin
          case ($urandom_range(0, 9))
            0:       a63 = '0;
            1:       if (g_step != 0) a63 = PAUSE_W'(r64 % (2 * g_step + 1));
            2:       if (g_step != 0) a63 = '1 >> $urandom_range(40, 62);
            default: a63 = PAUSE_W'(r64 % ((g_step == 0) ? 64'd3000 : 2 * g_step + 1));
          endcase
          send_item(FUNC_PAUSE, r64, a63, 1'b0, blank);
        end
      end
    end

    push = 1'b0;
    @(negedge clk);
    while (sched_results_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && sched_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fsss_pkg.sv
hw/rtl/fsss_cmd_q.sv
hw/rtl/fsss_res_q.sv
hw/rtl/fsss_front.sv
hw/rtl/fsss_back.sv
hw/rtl/fixed_timestep_step_scheduler.sv
sim/fixed_timestep_step_scheduler_tb.sv
